// ----- design/npcm_pkg.sv -----
// shared types and constants for the nearest palette color match block
package npcm_pkg;

  localparam int COLOR_W = 8;
  localparam int INDEX_W = 8;
  localparam int COUNT_W = 9;
  localparam int SQ_W    = 16;
  localparam int DIST_W  = 18;

  localparam logic               OP_WRITE    = 1'b0;
  localparam logic               OP_QUERY    = 1'b1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
  localparam logic [DIST_W-1:0]  DIST_INIT   = 18'h3FFFF;
  localparam logic [DIST_W-1:0]  DIST_MAX    = 18'd195075;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb_t;

  // tag that rides along with each palette read through the pipeline
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [INDEX_W-1:0] idx;
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_PUSH
  } state_t;

endpackage

// ----- design/npcm_palette_ram.sv -----
// palette color store, one write port and one registered read port
module npcm_palette_ram #(
  parameter int DEPTH = 256
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr,
  input  npcm_pkg::rgb_t             wr_data,
  input  logic                       rd_en,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr,
  output npcm_pkg::rgb_t             rd_data
);

  npcm_pkg::rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/npcm_dist_unit.sv -----
// two stage squared rgb distance: squares, then sum
module npcm_dist_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  npcm_pkg::rgb_t                query,
  input  npcm_pkg::rgb_t                entry,
  input  npcm_pkg::tag_t                tag_in,
  output logic [npcm_pkg::DIST_W-1:0]   dist_sq,
  output npcm_pkg::tag_t                tag_out
);

  logic signed [npcm_pkg::COLOR_W:0]     diff_red, diff_green, diff_blue;
  logic signed [2*npcm_pkg::COLOR_W+1:0] prod_red, prod_green, prod_blue;
  logic [npcm_pkg::SQ_W-1:0]             sq_red_r, sq_green_r, sq_blue_r;
  npcm_pkg::tag_t                        tag_a_r, tag_b_r;
  logic [npcm_pkg::DIST_W-1:0]           dist_r;

  // differences are signed, one bit wider than a component
  assign diff_red   = $signed({1'b0, query.red})   - $signed({1'b0, entry.red});
  assign diff_green = $signed({1'b0, query.green}) - $signed({1'b0, entry.green});
  assign diff_blue  = $signed({1'b0, query.blue})  - $signed({1'b0, entry.blue});
  assign prod_red   = diff_red * diff_red;
  assign prod_green = diff_green * diff_green;
  assign prod_blue  = diff_blue * diff_blue;

  always_ff @(posedge clk) begin
    sq_red_r   <= prod_red[npcm_pkg::SQ_W-1:0];
    sq_green_r <= prod_green[npcm_pkg::SQ_W-1:0];
    sq_blue_r  <= prod_blue[npcm_pkg::SQ_W-1:0];
    dist_r     <= npcm_pkg::DIST_W'(sq_red_r) + npcm_pkg::DIST_W'(sq_green_r)
                + npcm_pkg::DIST_W'(sq_blue_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
    end else begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
    end
  end

  assign dist_sq = dist_r;
  assign tag_out = tag_b_r;

endmodule

// ----- design/nearest_palette_color_match.sv -----
// top level: palette store, scan sequencer, best match search and result register
// a write is taken while idle and leaves input ready; a query scans n entries (n = searched count):
// one palette read a cycle, then read, square, sum, compare and result-load stages
// in_tready stays low until the result loads; a full result register stalls the load
// reset (rst_n low at an edge) idles the sequencer and empties the result register,
// palette_count resets to 256, palette contents are undefined until written
module nearest_palette_color_match #(
  parameter int PALETTE_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: palette_count
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  // input words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  logic [0:0]  in_tuser,   // opcode[0]
  // result words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // match_index[7:0], match_distance_sq[25:8], zeros[31:26]
);

  localparam int AW    = $clog2(PALETTE_SIZE);
  // most entries a query can search: the memory depth, and the 8-bit index range
  localparam int LIMIT = (PALETTE_SIZE < 256) ? PALETTE_SIZE : 256;

  npcm_pkg::state_t state_r, state_nxt;

  logic [npcm_pkg::COUNT_W-1:0] count_r;
  logic [npcm_pkg::COUNT_W-1:0] count_eff;
  logic [npcm_pkg::INDEX_W-1:0] last_r;
  logic [npcm_pkg::INDEX_W-1:0] scan_idx_r;
  npcm_pkg::rgb_t               query_r;

  logic                         in_opcode;
  logic [npcm_pkg::INDEX_W-1:0] in_entry_index;
  npcm_pkg::rgb_t               in_color;
  logic                         in_fire;
  logic                         query_fire;
  logic                         wr_en;

  logic                         rd_en;
  logic                         push;
  npcm_pkg::rgb_t               rd_data;
  npcm_pkg::tag_t               tag_rd;
  npcm_pkg::tag_t               tag_t1_r;
  npcm_pkg::tag_t               tag_cmp;
  logic [npcm_pkg::DIST_W-1:0]  dist_sq;

  logic [npcm_pkg::DIST_W-1:0]  best_dist_r;
  logic [npcm_pkg::INDEX_W-1:0] best_idx_r;

  logic                         out_valid_r;
  logic [npcm_pkg::INDEX_W-1:0] out_index_r;
  logic [npcm_pkg::DIST_W-1:0]  out_dist_r;

  // unpack the input word
  assign in_opcode      = in_tuser[0];
  assign in_entry_index = in_tdata[7:0];
  assign in_color.red   = in_tdata[15:8];
  assign in_color.green = in_tdata[23:16];
  assign in_color.blue  = in_tdata[31:24];

  assign in_fire    = in_tvalid && in_tready;
  assign query_fire = in_fire && (in_opcode == npcm_pkg::OP_QUERY);
  // writes beyond the palette depth are dropped
  assign wr_en      = in_fire && (in_opcode == npcm_pkg::OP_WRITE)
                   && (32'(in_entry_index) < PALETTE_SIZE);

  // searched count saturates to one from below and to the limit from above
  always_comb begin
    if (count_r == '0) begin
      count_eff = npcm_pkg::COUNT_W'(1);
    end else if (count_r > npcm_pkg::COUNT_W'(LIMIT)) begin
      count_eff = npcm_pkg::COUNT_W'(LIMIT);
    end else begin
      count_eff = count_r;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= npcm_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npcm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      npcm_pkg::ST_IDLE: begin
        if (query_fire) begin
          state_nxt = npcm_pkg::ST_SCAN;
        end
      end
      npcm_pkg::ST_SCAN: begin
        if (scan_idx_r == last_r) begin
          state_nxt = npcm_pkg::ST_DRAIN;
        end
      end
      npcm_pkg::ST_DRAIN: begin
        // wait for the last entry to leave the compare stage
        if (tag_cmp.valid && tag_cmp.last) begin
          state_nxt = npcm_pkg::ST_PUSH;
        end
      end
      npcm_pkg::ST_PUSH: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = npcm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = npcm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    push      = 1'b0;
    unique case (state_r)
      npcm_pkg::ST_IDLE:  in_tready = 1'b1;
      npcm_pkg::ST_SCAN:  rd_en     = 1'b1;
      npcm_pkg::ST_DRAIN: ;
      npcm_pkg::ST_PUSH:  push      = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  // scan address, query color and last index are captured when a query is taken
  always_ff @(posedge clk) begin
    if (query_fire) begin
      query_r    <= in_color;
      last_r     <= npcm_pkg::INDEX_W'(count_eff - npcm_pkg::COUNT_W'(1));
      scan_idx_r <= '0;
    end else if (rd_en) begin
      scan_idx_r <= scan_idx_r + npcm_pkg::INDEX_W'(1);
    end
  end

  npcm_palette_ram #(
    .DEPTH (PALETTE_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_entry_index)),
    .wr_data (in_color),
    .rd_en   (rd_en),
    .rd_addr (AW'(scan_idx_r)),
    .rd_data (rd_data)
  );

  // the tag is registered alongside the read to line up with the memory output
  assign tag_rd.valid = rd_en;
  assign tag_rd.last  = (scan_idx_r == last_r);
  assign tag_rd.idx   = scan_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_t1_r <= '0;
    end else begin
      tag_t1_r <= tag_rd;
    end
  end

  npcm_dist_unit u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .query   (query_r),
    .entry   (rd_data),
    .tag_in  (tag_t1_r),
    .dist_sq (dist_sq),
    .tag_out (tag_cmp)
  );

  // best so far; strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (query_fire) begin
      best_dist_r <= npcm_pkg::DIST_INIT;
      best_idx_r  <= '0;
    end else if (tag_cmp.valid && (dist_sq < best_dist_r)) begin
      best_dist_r <= dist_sq;
      best_idx_r  <= tag_cmp.idx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_index_r <= best_idx_r;
      out_dist_r  <= best_dist_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_dist_r, out_index_r};

endmodule

// ----- design/npcm_checker.sv -----
// port level checks for the nearest palette color match block, with its bind
module npcm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // reported distance stays within the rgb cube diagonal, padding is zero
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[25:8] <= npcm_pkg::DIST_MAX) && (out_tdata[31:26] == 6'b0))
    else $error("distance out of range");

  // a query occupies the block for the scan
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == npcm_pkg::OP_QUERY) |=> !in_tready)
    else $error("input ready right after a query");

  // a palette write leaves the block ready for the next word
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[0] == npcm_pkg::OP_WRITE) |=> in_tready)
    else $error("input not ready after a write");

  // a new result only appears at the end of a query scan
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared while idle");

endmodule

bind nearest_palette_color_match npcm_checker u_npcm_checker (.*);

// ----- sim/npcm_match_checker.sv -----
// checker for the nearest palette color match block: mirrors the palette and scores each result
module npcm_match_checker #(
  parameter int PALETTE_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          query_count,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [npcm_pkg::INDEX_W-1:0] idx;
    logic [npcm_pkg::DIST_W-1:0]  dist_sq;
  } match_t;

  npcm_pkg::rgb_t               palette_mirror [PALETTE_SIZE];
  logic [npcm_pkg::COUNT_W-1:0] searched_count;
  match_t                       expected_matches [$];

  // saturate the register to the range the search can use
  function automatic int active_entries(input logic [npcm_pkg::COUNT_W-1:0] cnt);
    int n;
    n = int'(cnt);
    if (n < 1) n = 1;
    if (n > PALETTE_SIZE) n = PALETTE_SIZE;
    if (n > 256) n = 256;
    return n;
  endfunction

  // closest mirrored entry, strict compare keeps the lowest index on ties
  function automatic match_t find_nearest(input npcm_pkg::rgb_t q);
    match_t m;
    int     best;
    int     d;
    int     dr;
    int     dg;
    int     db;
    int     n;
    n     = active_entries(searched_count);
    best  = 32'h7FFF_FFFF;
    m.idx = '0;
    for (int i = 0; i < n; i++) begin
      dr = int'(q.red)   - int'(palette_mirror[i].red);
      dg = int'(q.green) - int'(palette_mirror[i].green);
      db = int'(q.blue)  - int'(palette_mirror[i].blue);
      d  = dr * dr + dg * dg + db * db;
      if (d < best) begin
        best  = d;
        m.idx = npcm_pkg::INDEX_W'(i);
      end
    end
    m.dist_sq = best[npcm_pkg::DIST_W-1:0];
    return m;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on result word %0d: %s got %0h, expected %0h",
             $realtime, result_count, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    match_t         want;
    npcm_pkg::rgb_t q;
    if (!rst_n) begin
      searched_count = npcm_pkg::COUNT_RESET;
      expected_matches.delete();
    end else begin
      // results first so a word can never consume an expectation queued at this edge
      if (out_tvalid && out_tready) begin
        result_count++;
        if (expected_matches.size() == 0) begin
          report_mismatch("unexpected result word", out_tdata, '0);
        end else begin
          want = expected_matches.pop_front();
          if (out_tdata[7:0] !== want.idx)
            report_mismatch("match_index", 32'(out_tdata[7:0]), 32'(want.idx));
          if (out_tdata[25:8] !== want.dist_sq)
            report_mismatch("match_distance_sq", 32'(out_tdata[25:8]), 32'(want.dist_sq));
          if (out_tdata[31:26] !== 6'd0)
            report_mismatch("padding bits", 32'(out_tdata[31:26]), '0);
        end
      end
      if (in_tvalid && in_tready) begin
        q = {in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
        if (in_tuser[0] == npcm_pkg::OP_WRITE) begin
          if (int'(in_tdata[7:0]) < PALETTE_SIZE) palette_mirror[in_tdata[7:0]] = q;
        end else begin
          query_count++;
          expected_matches.insert(expected_matches.size(), find_nearest(q));
        end
      end
      if (cfg_we) searched_count = cfg_wdata;
    end
    pending_count <= expected_matches.size();
  end

endmodule

// ----- sim/nearest_palette_color_match_tb.sv -----
// testbench top for the nearest palette color match block: stimulus, flow control and verdict
module nearest_palette_color_match_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PALETTE_SIZE = 256;
  localparam int TARGET_ITEMS = 1950;
  // slowest pass is roughly 2000 full-palette queries, kept well clear
  localparam int RUN_LIMIT_NS = 30_000_000;

  // every input starts at a known value
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [8:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
  logic [0:0]  in_tuser   = '0;   // opcode[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // match_index[7:0], match_distance_sq[25:8], zeros[31:26]

  int fail_count;
  int pending_count;
  int query_count;
  int result_count;

  // stimulus-side view of the palette, only used to pick colors and avoid unwritten reads
  npcm_pkg::rgb_t palette_shadow [PALETTE_SIZE];
  bit             entry_loaded   [PALETTE_SIZE];
  int             items_sent     = 0;
  int             phases_run     = 0;
  int             active_count   = 256;

  nearest_palette_color_match #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  npcm_match_checker #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .query_count   (query_count),
    .result_count  (result_count)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout: %0d results still outstanding", pending_count);
    $display("Simulation FAILED");
    $finish;
  end

  // result side: stall a random number of cycles before each word, then hold ready
  // until the word is taken; at the taking edge only one new value is assigned
  initial begin : result_sink
    int stall;
    wait (rst_n);
    forever begin
      stall = $urandom_range(0, 9);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // component levels lean toward the extremes so that the largest distances show up
  function automatic npcm_pkg::rgb_t rand_color();
    logic [7:0] lv [3];
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 7))
        0:       lv[k] = 8'd0;
        1:       lv[k] = 8'd255;
        default: lv[k] = 8'($urandom_range(0, 255));
      endcase
    end
    return {lv[0], lv[1], lv[2]};
  endfunction

  // one input word with a random gap ahead of it; valid stays high for a back to back word
  task automatic send_word(input logic op, input logic [7:0] idx, input npcm_pkg::rgb_t c);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {c.blue, c.green, c.red, idx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (op == npcm_pkg::OP_WRITE) begin
      entry_loaded[idx]   = 1'b1;
      palette_shadow[idx] = c;
    end
  endtask

  // let the block go quiet: all results in, then a pause for a trailing write
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // register write only while idle; active_count tracks the saturated search length
  task automatic set_palette_count(input logic [8:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (value == 9'd0)       active_count = 1;
    else if (value > 9'd256) active_count = 256;
    else                     active_count = int'(value);
    phases_run++;
  endtask

  // one phase: load whatever searched entries are still blank, then mixed writes and queries
  task automatic run_phase(input int n_items);
    npcm_pkg::rgb_t c;
    logic [7:0]     idx;
    for (int i = 0; i < active_count; i++) begin
      if (!entry_loaded[i]) send_word(npcm_pkg::OP_WRITE, 8'(i), rand_color());
    end
    for (int j = 0; j < n_items; j++) begin
      idx = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 35) begin
        // writes mostly land inside the searched range so that they move the answer
        if ($urandom_range(0, 1) == 0) idx = 8'($urandom_range(0, active_count - 1));
        // a copy of a searched entry sets up a distance tie
        if ($urandom_range(0, 3) == 0) c = palette_shadow[$urandom_range(0, active_count - 1)];
        else c = rand_color();
        send_word(npcm_pkg::OP_WRITE, idx, c);
      end else begin
        case ($urandom_range(0, 3))
          0: c = palette_shadow[$urandom_range(0, active_count - 1)];
          1: begin
            // near miss of an existing entry
            c = palette_shadow[$urandom_range(0, active_count - 1)];
            c.red   = c.red   ^ 8'($urandom_range(0, 3));
            c.green = c.green ^ 8'($urandom_range(0, 3));
            c.blue  = c.blue  ^ 8'($urandom_range(0, 3));
          end
          default: c = rand_color();
        endcase
        send_word(npcm_pkg::OP_QUERY, idx, c);
      end
    end
  endtask

  initial begin : stimulus
    logic [8:0] next_count;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a count of zero falls back to entry 0 alone
    set_palette_count(9'd0);
    send_word(npcm_pkg::OP_WRITE, 8'd0,   npcm_pkg::rgb_t'({8'd0,   8'd0,   8'd0}));
    send_word(npcm_pkg::OP_WRITE, 8'd1,   npcm_pkg::rgb_t'({8'd255, 8'd255, 8'd255}));
    send_word(npcm_pkg::OP_WRITE, 8'd2,   npcm_pkg::rgb_t'({8'd255, 8'd255, 8'd255}));
    send_word(npcm_pkg::OP_WRITE, 8'd255, npcm_pkg::rgb_t'({8'd255, 8'd0,   8'd255}));
    // white against black only gives the largest distance
    send_word(npcm_pkg::OP_QUERY, 8'd255, npcm_pkg::rgb_t'({8'd255, 8'd255, 8'd255}));
    send_word(npcm_pkg::OP_QUERY, 8'd0,   npcm_pkg::rgb_t'({8'd0,   8'd0,   8'd0}));
    // three entries, the two white ones tie and the lower index must win
    set_palette_count(9'd3);
    send_word(npcm_pkg::OP_QUERY, 8'd7,   npcm_pkg::rgb_t'({8'd255, 8'd255, 8'd255}));
    send_word(npcm_pkg::OP_QUERY, 8'd0,   npcm_pkg::rgb_t'({8'd128, 8'd128, 8'd128}));
    send_word(npcm_pkg::OP_QUERY, 8'd0,   npcm_pkg::rgb_t'({8'd127, 8'd127, 8'd127}));
    send_word(npcm_pkg::OP_QUERY, 8'd0,   npcm_pkg::rgb_t'({8'd0,   8'd255, 8'd0}));
    // overwrite entry 0 and hit it exactly
    send_word(npcm_pkg::OP_WRITE, 8'd0,   npcm_pkg::rgb_t'({8'd0,   8'd255, 8'd0}));
    send_word(npcm_pkg::OP_QUERY, 8'd128, npcm_pkg::rgb_t'({8'd0,   8'd255, 8'd0}));

    // random phases: the first few pin the register extremes, the rest favor small palettes
    while (items_sent < TARGET_ITEMS) begin
      case (phases_run)
        2:  next_count = 9'd1;
        3:  next_count = 9'd256;
        4:  next_count = 9'd511;
        5:  next_count = 9'd0;
        6:  next_count = 9'd2;
        default: begin
          case ($urandom_range(0, 5))
            0:       next_count = 9'($urandom_range(1, 8));
            1:       next_count = 9'($urandom_range(1, 64));
            2:       next_count = 9'($urandom_range(1, 256));
            3:       next_count = 9'd256;
            4:       next_count = 9'($urandom_range(257, 511));
            default: next_count = 9'($urandom_range(9, 128));
          endcase
        end
      endcase
      set_palette_count(next_count);
      run_phase($urandom_range(40, 80));
    end

    // drain: every result in, then a further wait for anything stray
    wait_idle();
    repeat (300) @(posedge clk);

    $display("run covered %0d input words (%0d queries) across %0d palette count settings",
             items_sent, query_count, phases_run);
    $display("%0d result words checked, %0d mismatches", result_count, fail_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/npcm_pkg.sv
design/npcm_palette_ram.sv
design/npcm_dist_unit.sv
design/nearest_palette_color_match.sv
design/npcm_checker.sv
sim/npcm_match_checker.sv
sim/nearest_palette_color_match_tb.sv
